// File: hw/rtl/dttfp_pkg.sv
// dttfp_pkg: shared types and constants for the decimal text to fixed point block
// holds the job record passed from the character front end to the scaling back end
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package dttfp_pkg;

	// digit accumulator and fraction digit count widths
	localparam int DT_W = 64;
	localparam int FD_W = 4;

	// result field widths
	localparam int VALUE_W  = 48;
	localparam int STATUS_W = 2;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FORMAT   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// one finished string, ready for scaling
	typedef struct packed {
		logic [DT_W-1:0] dt;
		logic [FD_W-1:0] fd;
		logic            negative;
		logic            bad;
		logic            ovf;
	} job_t;

endpackage
`default_nettype wire

// File: hw/rtl/dttfp_front.sv
// dttfp_front: per-character classification, format checks and digit accumulation
// emits one job record per terminating nul character
// depends on dttfp_pkg
`timescale 1ns / 1ps
`default_nettype none
module dttfp_front #(
	parameter int MAX_FRAC_DIGITS = 8,
	parameter int INT_BITS        = 31
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              char_valid,
	output logic                   char_stall,
	input  wire logic [7:0]        ch,
	output logic                   push,
	output dttfp_pkg::job_t        push_job,
	input  wire logic              full
);

	localparam int DT_W = dttfp_pkg::DT_W;
	localparam int FD_W = dttfp_pkg::FD_W;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_POINT = 8'h2e;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [1:0] FC_OTHER       = 2'd0;
	localparam logic [1:0] FC_SIGN        = 2'd1;
	localparam logic [1:0] FC_DIGIT       = 2'd2;
	localparam logic [1:0] FC_DIGIT_POINT = 2'd3;

	localparam logic [1:0] POS_FIRST  = 2'd0;
	localparam logic [1:0] POS_SECOND = 2'd1;
	localparam logic [1:0] POS_THIRD  = 2'd2;
	localparam logic [1:0] POS_LATER  = 2'd3;

	localparam logic [DT_W-1:0] INT_LIMIT  = (DT_W'(1) << INT_BITS) - DT_W'(1);
	localparam logic [DT_W-1:0] FRAC_LIMIT = 64'd1844674407370955160;
	localparam logic [FD_W-1:0] FD_MAX     = FD_W'(MAX_FRAC_DIGITS);

	logic            lead_done_q, scan_active_q, digit_seen_q, letter_seen_q;
	logic            parse_active_q, point_seen_q, negative_q, format_bad_q, overflowed_q;
	logic [1:0]      pos_q, first_class_q, sign_count_q;
	logic [DT_W-1:0] dt_q;
	logic [FD_W-1:0] fd_q;

	logic            n_scan_active, n_digit_seen, n_letter_seen;
	logic            n_parse_active, n_point_seen, n_negative, n_format_bad, n_overflowed;
	logic [1:0]      n_pos, n_first_class, n_sign_count;
	logic [DT_W-1:0] n_dt, dt10;
	logic [FD_W-1:0] n_fd;

	logic accept, skip, is_dig, is_sgn, is_let, sign_first;

	assign char_stall = full;
	assign accept     = char_valid && !full;

	assign is_dig = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign is_sgn = (ch == CH_PLUS) || (ch == CH_MINUS);
	assign is_let = ((ch >= 8'h41) && (ch <= 8'h5a)) || ((ch >= 8'h61) && (ch <= 8'h7a));
	assign skip   = !lead_done_q && ((ch == CH_SPACE) || (ch == CH_TAB));
	assign sign_first = (pos_q == POS_FIRST) && is_sgn;

	// times ten plus the digit, as shifts and adds
	assign dt10 = (dt_q << 3) + (dt_q << 1) + DT_W'(ch[3:0]);

	always_comb begin
		n_pos          = pos_q;
		n_first_class  = first_class_q;
		n_negative     = negative_q;
		n_format_bad   = format_bad_q;
		n_scan_active  = scan_active_q;
		n_sign_count   = sign_count_q;
		n_digit_seen   = digit_seen_q;
		n_letter_seen  = letter_seen_q;
		n_parse_active = parse_active_q;
		n_point_seen   = point_seen_q;
		n_dt           = dt_q;
		n_fd           = fd_q;
		n_overflowed   = overflowed_q;

		// lookahead over the first three characters after whitespace
		unique case (pos_q)
			POS_FIRST: begin
				if (is_sgn) begin
					n_first_class = FC_SIGN;
					n_negative    = (ch == CH_MINUS);
				end else if (is_dig) begin
					n_first_class = FC_DIGIT;
				end else begin
					n_first_class = FC_OTHER;
					n_format_bad  = 1'b1;
				end
				n_pos = POS_SECOND;
			end
			POS_SECOND: begin
				if (first_class_q == FC_SIGN && !is_dig)
					n_format_bad = 1'b1;
				if (first_class_q == FC_DIGIT) begin
					if (ch == CH_POINT)
						n_first_class = FC_DIGIT_POINT;
					else if (!is_dig && ch != CH_NUL && ch != CH_COMMA && ch != CH_SPACE)
						n_format_bad = 1'b1;
				end
				n_pos = POS_THIRD;
			end
			POS_THIRD: begin
				if (first_class_q == FC_DIGIT_POINT && !is_dig)
					n_format_bad = 1'b1;
				n_pos = POS_LATER;
			end
			POS_LATER: begin
			end
		endcase

		// format scan
		if (scan_active_q && ch != CH_NUL) begin
			priority if (is_sgn) begin
				if (sign_count_q < 2'd2)
					n_sign_count = sign_count_q + 2'd1;
			end else if (is_dig) begin
				n_digit_seen = 1'b1;
			end else if (ch == CH_POINT) begin
			end else if (is_let) begin
				n_letter_seen = 1'b1;
			end else begin
				n_scan_active = 1'b0;
			end
		end

		// number accumulation
		if (ch != CH_NUL && !sign_first && parse_active_q) begin
			priority if (is_dig) begin
				if (!point_seen_q) begin
					if (!overflowed_q) begin
						if (dt10 > INT_LIMIT) begin
							n_overflowed = 1'b1;
							n_dt         = INT_LIMIT;
						end else begin
							n_dt = dt10;
						end
					end
				end else if (!overflowed_q && fd_q < FD_MAX && dt_q <= FRAC_LIMIT) begin
					n_dt = dt10;
					n_fd = fd_q + FD_W'(1);
				end
			end else if (ch == CH_POINT && !point_seen_q) begin
				n_point_seen = 1'b1;
			end else begin
				n_parse_active = 1'b0;
			end
		end
	end

	assign push              = accept && (ch == CH_NUL);
	assign push_job.dt       = n_dt;
	assign push_job.fd       = n_fd;
	assign push_job.negative = n_negative;
	assign push_job.bad      = n_format_bad || !digit_seen_q || (sign_count_q > 2'd1)
		|| letter_seen_q;
	assign push_job.ovf      = overflowed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_done_q    <= 1'b0;
			pos_q          <= POS_FIRST;
			first_class_q  <= FC_OTHER;
			scan_active_q  <= 1'b1;
			sign_count_q   <= 2'd0;
			digit_seen_q   <= 1'b0;
			letter_seen_q  <= 1'b0;
			parse_active_q <= 1'b1;
			point_seen_q   <= 1'b0;
			negative_q     <= 1'b0;
			dt_q           <= '0;
			fd_q           <= '0;
			format_bad_q   <= 1'b0;
			overflowed_q   <= 1'b0;
		end else if (accept && !skip) begin
			if (ch == CH_NUL) begin
				lead_done_q    <= 1'b0;
				pos_q          <= POS_FIRST;
				first_class_q  <= FC_OTHER;
				scan_active_q  <= 1'b1;
				sign_count_q   <= 2'd0;
				digit_seen_q   <= 1'b0;
				letter_seen_q  <= 1'b0;
				parse_active_q <= 1'b1;
				point_seen_q   <= 1'b0;
				negative_q     <= 1'b0;
				dt_q           <= '0;
				fd_q           <= '0;
				format_bad_q   <= 1'b0;
				overflowed_q   <= 1'b0;
			end else begin
				lead_done_q    <= 1'b1;
				pos_q          <= n_pos;
				first_class_q  <= n_first_class;
				scan_active_q  <= n_scan_active;
				sign_count_q   <= n_sign_count;
				digit_seen_q   <= n_digit_seen;
				letter_seen_q  <= n_letter_seen;
				parse_active_q <= n_parse_active;
				point_seen_q   <= n_point_seen;
				negative_q     <= n_negative;
				dt_q           <= n_dt;
				fd_q           <= n_fd;
				format_bad_q   <= n_format_bad;
				overflowed_q   <= n_overflowed;
			end
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/dttfp_queue.sv
// dttfp_queue: short first-in first-out queue of job records
// sits between the character front end and the scaling back end
// depends on dttfp_pkg
`timescale 1ns / 1ps
`default_nettype none
module dttfp_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire dttfp_pkg::job_t  push_job,
	output logic                  full,
	input  wire logic             pop,
	output dttfp_pkg::job_t       pop_job,
	output logic                  empty
);

	localparam int DEPTH = dttfp_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	dttfp_pkg::job_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/dttfp_back.sv
// dttfp_back: scales the digit total by a power of ten as repeated division by ten,
// one 16-bit chunk per cycle; saturates, signs and registers the result; depends on dttfp_pkg
`timescale 1ns / 1ps
`default_nettype none
module dttfp_back #(
	parameter int FRAC_BITS = 16,
	parameter int INT_BITS  = 31
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  empty,
	output logic                                       pop,
	input  wire dttfp_pkg::job_t                       pop_job,
	output logic                                       res_valid,
	input  wire logic                                  res_stall,
	output logic signed [dttfp_pkg::VALUE_W-1:0]       value,
	output logic        [dttfp_pkg::STATUS_W-1:0]      status
);

	localparam int DT_W     = dttfp_pkg::DT_W;
	localparam int FD_W     = dttfp_pkg::FD_W;
	localparam int VALUE_W  = dttfp_pkg::VALUE_W;
	localparam int NUM_W    = DT_W + FRAC_BITS;
	localparam int CHUNK_W  = 16;
	localparam int N_CHUNKS = (NUM_W + CHUNK_W - 1) / CHUNK_W;
	localparam int PAD_W    = N_CHUNKS * CHUNK_W;
	localparam int CHK_W    = $clog2(N_CHUNKS);
	localparam int PART_W   = CHUNK_W + 4;
	localparam int RECIP_SH = 23;
	localparam logic [PART_W-1:0] RECIP10 = PART_W'(838861);
	localparam logic [FD_W-1:0]   MAX_STEPS = FD_W'(9);
	localparam int MAG_BITS = (INT_BITS + FRAC_BITS > VALUE_W - 1) ? VALUE_W - 1
		: INT_BITS + FRAC_BITS;
	localparam logic [PAD_W-1:0] MAXPOS = (PAD_W'(1) << MAG_BITS) - PAD_W'(1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]          st_q;
	logic [PAD_W-1:0]    num_q;
	logic [3:0]          rem_q;
	logic [CHK_W-1:0]    chk_q;
	logic [FD_W-1:0]     step_q;
	logic                neg_q, bad_q, ovf_q, res_valid_q;

	logic [PART_W-1:0]   part, q10;
	logic [2*PART_W-1:0] prod;
	logic [CHUNK_W-1:0]  q_c;
	logic [3:0]          r_c;
	logic [FD_W-1:0]     steps;
	logic                ovf_f, out_load;
	logic [PAD_W-1:0]    mag;
	logic [VALUE_W-1:0]  mag_v;

	// running remainder and top chunk, divided by ten through a reciprocal
	assign part  = {rem_q, num_q[PAD_W-1 -: CHUNK_W]};
	assign prod  = part * RECIP10;
	assign q_c   = prod[RECIP_SH +: CHUNK_W];
	assign q10   = (PART_W'(q_c) << 3) + (PART_W'(q_c) << 1);
	assign r_c   = 4'(part - q10);
	assign steps = (pop_job.fd > MAX_STEPS) ? MAX_STEPS : pop_job.fd;

	assign ovf_f  = ovf_q || (num_q > MAXPOS);
	assign mag    = ovf_f ? (neg_q ? MAXPOS + PAD_W'(1) : MAXPOS) : num_q;
	assign mag_v  = mag[VALUE_W-1:0];

	assign pop      = (st_q == ST_IDLE) && !empty;
	assign out_load = (st_q == ST_DONE) && (!res_valid_q || !res_stall);
	assign res_valid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			chk_q       <= '0;
			step_q      <= '0;
			rem_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (!empty) begin
						st_q   <= (steps == '0) ? ST_DONE : ST_DIV;
						step_q <= steps;
						chk_q  <= CHK_W'(N_CHUNKS - 1);
						rem_q  <= '0;
					end
				end
				ST_DIV: begin
					if (chk_q == '0) begin
						// one division by ten done, start the next from the top
						chk_q  <= CHK_W'(N_CHUNKS - 1);
						rem_q  <= '0;
						step_q <= step_q - FD_W'(1);
						if (step_q == FD_W'(1))
							st_q <= ST_DONE;
					end else begin
						chk_q <= chk_q - CHK_W'(1);
						rem_q <= r_c;
					end
				end
				ST_DONE: begin
					if (out_load)
						st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
			if (out_load)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	// scaled total, rotated a chunk per cycle while dividing, and result register
	always_ff @(posedge clk) begin
		if (pop) begin
			num_q <= PAD_W'({pop_job.dt, {FRAC_BITS{1'b0}}});
			neg_q <= pop_job.negative;
			bad_q <= pop_job.bad;
			ovf_q <= pop_job.ovf;
		end else if (st_q == ST_DIV) begin
			num_q <= {num_q[PAD_W-CHUNK_W-1:0], q_c};
		end
		if (out_load) begin
			value  <= neg_q ? -mag_v : mag_v;
			status <= bad_q ? dttfp_pkg::STATUS_FORMAT
				: (ovf_f ? dttfp_pkg::STATUS_OVERFLOW : dttfp_pkg::STATUS_OK);
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/decimal_text_to_fixed_point.sv
// decimal_text_to_fixed_point: top level of the decimal text parser
// joins dttfp_front, dttfp_queue and dttfp_back; depends on dttfp_pkg
//
// usage
//   characters enter one per transaction on char_valid / char_stall / ch
//   a nul character ends a string and yields one result transaction on
//   res_valid / res_stall / value / status (0 ok, 1 format error, 2 overflow)
//   value is two's complement with FRAC_BITS fraction bits, truncated
// rates and flow
//   the front end takes one character per cycle while the queue has room
//   the back end divides by ten once per kept fraction digit F, one 16-bit
//   chunk per cycle over C = ceil((64 + FRAC_BITS) / 16) chunks (5 at default)
//   the back end takes no new string until the previous result has been
//   loaded into the output register and the back end is idle again
//   char_stall is high while the two-entry queue of finished strings is full
// reset and stall
//   arst_n clears the parser state, empties the queue and drops res_valid
//   a stalled result holds in the output register; the next string waits
//   finished behind it, the queue fills and char_stall rises
`timescale 1ns / 1ps
`default_nettype none
module decimal_text_to_fixed_point #(
	parameter int FRAC_BITS       = 16,
	parameter int MAX_FRAC_DIGITS = 8,
	parameter int INT_BITS        = 31
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// character channel
	input  wire logic                                  char_valid,
	output logic                                       char_stall,
	input  wire logic [7:0]                            ch,
	// result channel
	output logic                                       res_valid,
	input  wire logic                                  res_stall,
	output logic signed [dttfp_pkg::VALUE_W-1:0]       value,
	output logic        [dttfp_pkg::STATUS_W-1:0]      status
);

	// job records between front end and back end
	logic            push, full, pop, empty;
	dttfp_pkg::job_t push_job, pop_job;

	// front end: whitespace skip, lookahead checks, scan, digit accumulation
	dttfp_front #(
		.MAX_FRAC_DIGITS (MAX_FRAC_DIGITS),
		.INT_BITS        (INT_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.ch         (ch),
		.push       (push),
		.push_job   (push_job),
		.full       (full)
	);

	// decoupling queue, lets the front end run on while the back end scales
	dttfp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (empty)
	);

	// back end: power of ten scaling, saturation, sign and output register
	dttfp_back #(
		.FRAC_BITS (FRAC_BITS),
		.INT_BITS  (INT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.pop       (pop),
		.pop_job   (pop_job),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.value     (value),
		.status    (status)
	);

endmodule
`default_nettype wire
